// File: rtl/oversampled_frame_receiver_unit_macros.svh
// Assertion shorthands used by the checker file.
`ifndef OVERSAMPLED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define OVERSAMPLED_FRAME_RECEIVER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ofr_pkg.sv
package ofr_pkg;

    // Framing geometry
    localparam int SAMPLES_PER_BIT = 10;
    localparam int FRAME_BYTES     = 7;
    localparam int WINDOWS         = 10;
    localparam int START_WINDOW    = 0;
    localparam int STOP_WINDOW     = 8;
    localparam int FIELD_COUNT     = 7;

    // Field widths
    localparam int SAMPLE_W   = 10;
    localparam int VOTE_W     = 4;
    localparam int CHAR_W     = 7;
    localparam int COUNT_W    = 4;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    // Derived widths
    localparam int TICK_W    = $clog2(SAMPLES_PER_BIT);
    localparam int WIN_W     = $clog2(WINDOWS + 1);
    localparam int IDX_W     = $clog2(FRAME_BYTES + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register reset values
    localparam logic [SAMPLE_W-1:0] LEVEL_THRESHOLD_RST = SAMPLE_W'(900);
    localparam logic [VOTE_W-1:0]   VOTE_MINIMUM_RST    = VOTE_W'(6);
    localparam logic [CHAR_W-1:0]   START_TEXT_RST      = CHAR_W'(8'h70);
    localparam logic [CHAR_W-1:0]   END_TEXT_RST        = CHAR_W'(8'h71);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_THRESHOLD,
        CFG_VOTE_MINIMUM,
        CFG_START_TEXT,
        CFG_END_TEXT
    } cfg_index_t;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [FIELD_COUNT-1:0][CHAR_W-1:0] field_vec_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level_threshold;
        logic [VOTE_W-1:0]   vote_minimum;
        char_t               start_text_code;
        char_t               end_text_code;
    } ofr_cfg_t;

    typedef struct packed {
        char_t char_value;
        logic  frame_error;
    } ofr_verdict_t;

endpackage

// File: rtl/ofr_if.sv
interface ofr_sample_if;
    import ofr_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source(output valid, output sample, input ready);
    modport sink(input valid, input sample, output ready);
endinterface

interface ofr_result_if;
    import ofr_pkg::*;
    logic  valid;
    logic  ready;
    char_t char_value;
    logic  frame_error;
    logic  frame_done;
    char_t field_zero;
    char_t field_one;
    char_t field_two;
    char_t field_three;
    char_t field_four;
    char_t field_five;
    char_t field_six;

    modport source(output valid, output char_value, output frame_error, output frame_done,
                   output field_zero, output field_one, output field_two, output field_three,
                   output field_four, output field_five, output field_six, input ready);
    modport sink(input valid, input char_value, input frame_error, input frame_done,
                 input field_zero, input field_one, input field_two, input field_three,
                 input field_four, input field_five, input field_six, output ready);
endinterface

interface ofr_cfg_if;
    import ofr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/ofr_sampler.sv
module ofr_sampler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [ofr_pkg::SAMPLE_W-1:0]   sample,
    input  ofr_pkg::ofr_cfg_t              cfg,
    output logic                           judge,
    output ofr_pkg::ofr_verdict_t          verdict
);
    import ofr_pkg::*;

    logic                busy_reg, busy_next;
    logic [WIN_W-1:0]    win_reg, win_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [COUNT_W-1:0]  count_reg  [WINDOWS];
    logic [COUNT_W-1:0]  count_next [WINDOWS];
    logic                high;
    logic                frame_ok;
    char_t               bits;

    assign high  = (sample >= cfg.level_threshold);
    assign judge = busy_reg && (win_reg == WIN_W'(WINDOWS));

    // Advance tick and window, bump the current window on a high sample; clear all on judging
    always_comb
    begin
        busy_next = busy_reg;
        win_next  = win_reg;
        tick_next = tick_reg;
        for (int w = 0; w < WINDOWS; w++)
        begin
            count_next[w] = count_reg[w];
        end
        if (step)
        begin
            if (judge)
            begin
                busy_next = 1'b0;
                win_next  = '0;
                tick_next = '0;
                for (int w = 0; w < WINDOWS; w++)
                begin
                    count_next[w] = '0;
                end
            end
            else if (busy_reg || high)
            begin
                busy_next = 1'b1;
                for (int w = 0; w < WINDOWS; w++)
                begin
                    if (high && (win_reg == WIN_W'(w)) && (count_reg[w] != COUNT_MAX))
                    begin
                        count_next[w] = count_reg[w] + COUNT_W'(1);
                    end
                end
                if (tick_reg == TICK_W'(SAMPLES_PER_BIT - 1))
                begin
                    tick_next = '0;
                    win_next  = win_reg + WIN_W'(1);
                end
                else
                begin
                    tick_next = tick_reg + TICK_W'(1);
                end
            end
        end
    end

    // Vote the start, data and stop windows; data bits come MSB first from windows 1 to 7
    always_comb
    begin
        for (int k = 0; k < CHAR_W; k++)
        begin
            bits[CHAR_W-1-k] = (count_reg[k+1] >= cfg.vote_minimum);
        end
        frame_ok = (count_reg[START_WINDOW] >= cfg.vote_minimum) &&
                   (count_reg[STOP_WINDOW] >= cfg.vote_minimum);
        verdict.char_value  = frame_ok ? bits : '0;
        verdict.frame_error = !frame_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            win_reg  <= '0;
            tick_reg <= '0;
            for (int w = 0; w < WINDOWS; w++)
            begin
                count_reg[w] <= '0;
            end
        end
        else
        begin
            busy_reg <= busy_next;
            win_reg  <= win_next;
            tick_reg <= tick_next;
            for (int w = 0; w < WINDOWS; w++)
            begin
                count_reg[w] <= count_next[w];
            end
        end
    end

endmodule

// File: rtl/ofr_assembler.sv
module ofr_assembler (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  commit,
    input  ofr_pkg::ofr_verdict_t verdict,
    input  ofr_pkg::ofr_cfg_t     cfg,
    output logic                  frame_done,
    output ofr_pkg::field_vec_t   fields
);
    import ofr_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    char_t            buf_reg      [FRAME_BYTES];
    char_t            buf_next     [FRAME_BYTES];
    char_t            latched_reg  [FRAME_BYTES];
    char_t            latched_next [FRAME_BYTES];
    logic             is_start;
    logic             is_end;

    // Start of text wins when both codes match
    assign is_start   = (verdict.char_value == cfg.start_text_code);
    assign is_end     = !is_start && (verdict.char_value == cfg.end_text_code);
    assign frame_done = !verdict.frame_error && is_end;

    // Store, latch or reset index on a good character
    always_comb
    begin
        idx_next = idx_reg;
        for (int b = 0; b < FRAME_BYTES; b++)
        begin
            buf_next[b]     = buf_reg[b];
            latched_next[b] = latched_reg[b];
        end
        if (commit && !verdict.frame_error)
        begin
            if (is_start)
            begin
                idx_next = '0;
            end
            else if (is_end)
            begin
                idx_next = '0;
                for (int b = 0; b < FRAME_BYTES; b++)
                begin
                    latched_next[b] = buf_reg[b];
                end
            end
            else if (idx_reg < IDX_W'(FRAME_BYTES))
            begin
                for (int b = 0; b < FRAME_BYTES; b++)
                begin
                    if (idx_reg == IDX_W'(b))
                    begin
                        buf_next[b] = verdict.char_value;
                    end
                end
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    // Drive the fields from the latched bytes, and any slot beyond the frame with zero
    for (genvar i = 0; i < FIELD_COUNT; i++)
    begin : g_field
        if (i < FRAME_BYTES)
        begin : g_live
            assign fields[i] = latched_reg[i];
        end
        else
        begin : g_zero
            assign fields[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            for (int b = 0; b < FRAME_BYTES; b++)
            begin
                buf_reg[b]     <= '0;
                latched_reg[b] <= '0;
            end
        end
        else
        begin
            idx_reg <= idx_next;
            for (int b = 0; b < FRAME_BYTES; b++)
            begin
                buf_reg[b]     <= buf_next[b];
                latched_reg[b] <= latched_next[b];
            end
        end
    end

endmodule

// File: rtl/oversampled_frame_receiver_unit.sv
// A result is registered when the held beat carrying its judging sample is processed.
// Throughput: one sample beat per cycle; only a judging beat waits for a free result slot.
// Every window boundary, after ten samples, is counted by a tick/window counter pair, no divider.
// Reset (rst_n, async, active low) clears control registers to defaults, the sampler to
// idle hunting, all window counts, the byte index and both frame buffers.
module oversampled_frame_receiver_unit (
    input  logic         clk,
    input  logic         rst_n,
    ofr_sample_if.sink   samples,
    ofr_result_if.source results,
    ofr_cfg_if.sink      cfg
);
    import ofr_pkg::*;

    ofr_cfg_t            cfg_reg;
    logic                smp_valid_reg, smp_valid_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                res_valid_reg, res_valid_next;
    char_t               char_reg;
    logic                error_reg;
    logic                done_reg;
    logic                judge;
    logic                advance;
    logic                frame_done;
    ofr_verdict_t        verdict;
    field_vec_t          fields;

    assign cfg.ready = 1'b1;

    // Process the held beat unless it judges and the result slot is stuck
    assign advance = smp_valid_reg && (!judge || !res_valid_reg || results.ready);
    assign samples.ready = !smp_valid_reg || advance;

    always_comb
    begin
        smp_valid_next = smp_valid_reg;
        if (samples.valid && samples.ready)
        begin
            smp_valid_next = 1'b1;
        end
        else if (advance)
        begin
            smp_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (advance && judge)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    ofr_sampler u_sampler (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .sample  (sample_reg),
        .cfg     (cfg_reg),
        .judge   (judge),
        .verdict (verdict)
    );

    ofr_assembler u_assembler (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (advance && judge),
        .verdict    (verdict),
        .cfg        (cfg_reg),
        .frame_done (frame_done),
        .fields     (fields)
    );

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg           <= 1'b0;
            res_valid_reg           <= 1'b0;
            cfg_reg.level_threshold <= LEVEL_THRESHOLD_RST;
            cfg_reg.vote_minimum    <= VOTE_MINIMUM_RST;
            cfg_reg.start_text_code <= START_TEXT_RST;
            cfg_reg.end_text_code   <= END_TEXT_RST;
        end
        else
        begin
            smp_valid_reg <= smp_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_LEVEL_THRESHOLD: cfg_reg.level_threshold <= cfg.data[SAMPLE_W-1:0];
                    CFG_VOTE_MINIMUM:    cfg_reg.vote_minimum    <= cfg.data[VOTE_W-1:0];
                    CFG_START_TEXT:      cfg_reg.start_text_code <= cfg.data[CHAR_W-1:0];
                    CFG_END_TEXT:        cfg_reg.end_text_code   <= cfg.data[CHAR_W-1:0];
                    default:             cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    // Payload registers: hold the input beat and the judged result
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            sample_reg <= samples.sample;
        end
        if (advance && judge)
        begin
            char_reg  <= verdict.char_value;
            error_reg <= verdict.frame_error;
            done_reg  <= frame_done;
        end
    end

    assign results.valid       = res_valid_reg;
    assign results.char_value  = char_reg;
    assign results.frame_error = error_reg;
    assign results.frame_done  = done_reg;
    // Latched fields change only together with a new result
    assign results.field_zero  = fields[0];
    assign results.field_one   = fields[1];
    assign results.field_two   = fields[2];
    assign results.field_three = fields[3];
    assign results.field_four  = fields[4];
    assign results.field_five  = fields[5];
    assign results.field_six   = fields[6];

endmodule

// File: rtl/ofr_checker.sv
`include "oversampled_frame_receiver_unit_macros.svh"

module ofr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           res_valid,
    input logic           res_ready,
    input ofr_pkg::char_t char_value,
    input logic           frame_error,
    input logic           frame_done
);
    import ofr_pkg::*;

    // A stalled result beat must stay offered
    `OFR_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")

    // A framing error carries a zero character
    `OFR_ASSERT_SAME(a_err_zero, clk, rst_n, res_valid && frame_error, char_value == '0, "nonzero character on framing error")

    // A failed frame never completes a text block
    `OFR_ASSERT_SAME(a_err_done, clk, rst_n, res_valid, !(frame_error && frame_done), "frame done on framing error")

endmodule

bind oversampled_frame_receiver_unit ofr_checker u_ofr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .char_value  (results.char_value),
    .frame_error (results.frame_error),
    .frame_done  (results.frame_done)
);
